### design/gcrse_pkg.sv
package gcrse_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Sector layout
  localparam logic [9:0] SECTOR_LAST = 10'd523;
  localparam logic [9:0] TRIPLE_END  = 10'd522;

  // Raw marks
  localparam logic [7:0] MARK_SYNC = 8'hFF;
  localparam logic [7:0] MARK_D5   = 8'hD5;
  localparam logic [7:0] MARK_AA   = 8'hAA;
  localparam logic [7:0] MARK_96   = 8'h96;
  localparam logic [7:0] MARK_AD   = 8'hAD;
  localparam logic [7:0] MARK_DE   = 8'hDE;

  // Format bytes
  localparam logic [7:0] FMT_DOUBLE = 8'h22;
  localparam logic [7:0] FMT_SINGLE = 8'h02;

  // 6-bit group to disk codeword
  localparam logic [7:0] CODEWORD_ROM [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  // Kind of work handed from front to back
  typedef enum logic [2:0] {
    JOB_HEADER = 3'b001,
    JOB_TRIPLE = 3'b010,
    JOB_LAST   = 3'b100
  } job_kind_e;

  // Header: b0 track, b1 sector, b2 side field, b3 format.
  // Triple: b0..b2 scrambled bytes. Last: b0, b1 scrambled, b2..b4 checksums.
  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } job_t;

  // Index of the final word of a job
  function automatic logic [4:0] job_last_idx(input job_kind_e kind);
    logic [4:0] n;
    unique case (kind)
      JOB_HEADER: n = 5'd24;
      JOB_TRIPLE: n = 5'd3;
      JOB_LAST:   n = 5'd9;
      default:    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] gcr_code(input logic [7:0] v);
    return CODEWORD_ROM[v[5:0]];
  endfunction

endpackage

### design/gcrse_in_if.sv
interface gcrse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [6:0] track_number;
  logic [3:0] sector_number;
  logic       side_select;

  modport source (
    output valid, data_byte, track_number, sector_number, side_select,
    input  ready
  );
  modport sink (
    input  valid, data_byte, track_number, sector_number, side_select,
    output ready
  );
endinterface

### design/gcrse_out_if.sv
interface gcrse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] disk_byte;
  logic       run_last;
  logic       sector_end;

  modport source (
    output valid, disk_byte, run_last, sector_end,
    input  ready
  );
  modport sink (
    input  valid, disk_byte, run_last, sector_end,
    output ready
  );
endinterface

### design/gcr_sector_encoder.sv
// 3.5-inch GCR 6-and-2 sector encoder.
// in_i takes one sector byte per word (12 tag bytes, then 512 data bytes);
// track, sector and side are sampled with the first byte of each sector.
// out_o gives disk bytes in track order, one word per cycle at most;
// run_last marks the final word caused by an input word, sector_end the
// final word of the sector. cfg_we_i/cfg_wdata_i write double_sided.
// The first byte yields 25 words, each byte closing a triple yields 4,
// the last byte yields 10, all others none.
// Each job passes through the job queue and then the output word register.
// The front takes one word per cycle while the job queue has room; the
// back emits one word per cycle while the receiver is ready and a job is
// queued, so the output sets throughput: 4 disk words per 3 data bytes,
// 731 words per 524-byte sector, with the queue letting the front run ahead
// of the back while the 25-word header goes out.
// Reset clears position, checksums, queue and output valid, and sets
// double_sided to 1. When the receiver stalls, the output word holds, the
// queue fills and then in_i.ready drops.
module gcr_sector_encoder import gcrse_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  gcrse_in_if.sink    in_i,
  gcrse_out_if.source out_o
);

  logic double_sided_q;
  logic push, full, pop, job_valid;
  job_t push_job, head_job;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      double_sided_q <= 1'b1;
    end else if (cfg_we_i) begin
      double_sided_q <= cfg_wdata_i;
    end
  end

  gcrse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .double_sided_i (double_sided_q),
    .in_i           (in_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  gcrse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  gcrse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

### design/gcrse_front.sv
module gcrse_front import gcrse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        double_sided_i,
  gcrse_in_if.sink    in_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [9:0] pos_q, pos_d;
  logic [1:0] phase_q, phase_d;
  logic [8:0] sum_a_q, sum_b_q, sum_c_q;
  logic [7:0] x_q, y_q;

  logic       accept, first, is_last;
  logic [7:0] byte_w, sa_base, sc_base, c_rot, x_new, y_new, z_new;
  logic [8:0] sa_new, sb_new, sc_new;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign byte_w     = in_i.data_byte;
  assign first      = (pos_q == '0);
  assign is_last    = (pos_q == SECTOR_LAST);

  // Scramble one byte of the triple, checksums restart on a new sector
  assign sa_base = first ? 8'h00 : sum_a_q[7:0];
  assign sc_base = first ? 8'h00 : sum_c_q[7:0];
  assign c_rot   = {sc_base[6:0], sc_base[7]};
  assign sa_new  = {1'b0, sa_base} + {1'b0, byte_w} + {8'h00, c_rot[0]};
  assign x_new   = byte_w ^ c_rot;
  assign sb_new  = {1'b0, sum_b_q[7:0]} + {1'b0, byte_w} + {8'h00, sum_a_q[8]};
  assign y_new   = byte_w ^ sum_a_q[7:0];
  assign sc_new  = {1'b0, sum_c_q[7:0]} + {1'b0, byte_w} + {8'h00, sum_b_q[8]};
  assign z_new   = byte_w ^ sum_b_q[7:0];

  // Advance sector position and triple phase
  always_comb begin
    if (is_last) begin
      pos_d   = '0;
      phase_d = 2'd0;
    end else begin
      pos_d   = pos_q + 10'd1;
      phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
    end
  end

  // Classify the word and build its job
  always_comb begin
    push_o  = 1'b0;
    job_o   = '{kind: JOB_TRIPLE, b0: x_q, b1: y_q, b2: z_new, b3: 8'h00, b4: 8'h00};
    if (first) begin
      push_o = accept;
      job_o  = '{kind: JOB_HEADER,
                 b0: {1'b0, in_i.track_number},
                 b1: {4'h0, in_i.sector_number},
                 b2: {2'b00, in_i.side_select, 4'h0, in_i.track_number[6]},
                 b3: double_sided_i ? FMT_DOUBLE : FMT_SINGLE,
                 b4: 8'h00};
    end else if (is_last) begin
      push_o = accept;
      job_o  = '{kind: JOB_LAST, b0: x_q, b1: y_new, b2: sum_a_q[7:0],
                 b3: sb_new[7:0], b4: sum_c_q[7:0]};
    end else if (phase_q == 2'd2) begin
      push_o = accept;
    end
  end

  // Hold position and checksums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= 2'd0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      sum_c_q <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      if (phase_q == 2'd0) begin
        sum_c_q <= {1'b0, c_rot};
        sum_a_q <= sa_new;
        if (first) begin
          sum_b_q <= '0;
        end
      end else if (phase_q == 2'd1) begin
        sum_b_q <= sb_new;
      end else begin
        sum_c_q <= sc_new;
      end
    end
  end

  // Hold scrambled bytes until the triple closes
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == 2'd0) begin
      x_q <= x_new;
    end
    if (accept && phase_q == 2'd1) begin
      y_q <= y_new;
    end
  end

endmodule

### design/gcrse_queue.sv
module gcrse_queue import gcrse_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign job_o   = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### design/gcrse_back.sv
module gcrse_back import gcrse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  gcrse_out_if.source out_o
);

  logic [4:0] idx_q;
  logic       out_valid_q;
  logic [7:0] disk_byte_q;
  logic       run_last_q, sector_end_q;

  logic       load, at_end;
  logic [7:0] word_d, hdr_xor;

  assign load   = job_valid_i && (!out_valid_q || out_o.ready);
  assign at_end = (idx_q == job_last_idx(job_i.kind));
  assign pop_o  = load && at_end;

  assign hdr_xor = job_i.b0 ^ job_i.b1 ^ job_i.b2 ^ job_i.b3;

  // Pick the word for this step of the job
  always_comb begin
    word_d = MARK_SYNC;
    unique case (job_i.kind)
      JOB_HEADER: begin
        unique case (idx_q) inside
          [5'd0:5'd4], 5'd15, [5'd16:5'd20]: word_d = MARK_SYNC;
          5'd5, 5'd21: word_d = MARK_D5;
          5'd6, 5'd14, 5'd22: word_d = MARK_AA;
          5'd7:  word_d = MARK_96;
          5'd8:  word_d = gcr_code(job_i.b0);
          5'd9, 5'd24: word_d = gcr_code(job_i.b1);
          5'd10: word_d = gcr_code(job_i.b2);
          5'd11: word_d = gcr_code(job_i.b3);
          5'd12: word_d = gcr_code(hdr_xor);
          5'd13: word_d = MARK_DE;
          5'd23: word_d = MARK_AD;
          default: word_d = MARK_SYNC;
        endcase
      end
      JOB_TRIPLE: begin
        unique case (idx_q)
          5'd0: word_d = gcr_code({2'b00, job_i.b0[7:6], job_i.b1[7:6], job_i.b2[7:6]});
          5'd1: word_d = gcr_code(job_i.b0);
          5'd2: word_d = gcr_code(job_i.b1);
          5'd3: word_d = gcr_code(job_i.b2);
          default: word_d = MARK_SYNC;
        endcase
      end
      JOB_LAST: begin
        unique case (idx_q)
          5'd0: word_d = gcr_code({2'b00, job_i.b0[7:6], job_i.b1[7:6], 2'b00});
          5'd1: word_d = gcr_code(job_i.b0);
          5'd2: word_d = gcr_code(job_i.b1);
          5'd3: word_d = gcr_code({2'b00, job_i.b2[7:6], job_i.b3[7:6], job_i.b4[7:6]});
          5'd4: word_d = gcr_code(job_i.b2);
          5'd5: word_d = gcr_code(job_i.b3);
          5'd6: word_d = gcr_code(job_i.b4);
          5'd7: word_d = MARK_DE;
          5'd8: word_d = MARK_AA;
          default: word_d = MARK_SYNC;
        endcase
      end
      default: word_d = MARK_SYNC;
    endcase
  end

  // Step through the job and drop the valid once the word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      idx_q       <= at_end ? '0 : idx_q + 5'd1;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      disk_byte_q  <= word_d;
      run_last_q   <= at_end;
      sector_end_q <= at_end && (job_i.kind == JOB_LAST);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.disk_byte  = disk_byte_q;
  assign out_o.run_last   = run_last_q;
  assign out_o.sector_end = sector_end_q;

endmodule
